// ===== hw/rtl/log_bucket_histogram_stats_assert.svh =====
// Assertion macros for the log-bucket histogram checker.
// Each macro expands to one labelled concurrent assertion that reports by $error.
// Used by lbh_chk.sv; no other dependencies.
`ifndef LOG_BUCKET_HISTOGRAM_STATS_ASSERT_SVH
`define LOG_BUCKET_HISTOGRAM_STATS_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define LBH_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define LBH_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lbh_pkg.sv =====
// Shared types and constants for the log-bucket histogram block.
// No dependencies; imported by lbh_mul, the top level and lbh_chk (lbh_ram does not use it).
`default_nettype none

package lbh_pkg;

  localparam int LBH_NUM_BUCKETS_DEF = 64;
  localparam int LBH_SAMPLE_BITS_DEF = 32;

  localparam int LBH_SAMPLE_W = 32;
  localparam int LBH_INDEX_W  = 6;
  localparam int LBH_COUNT_W  = 32;
  localparam int LBH_STAT_W   = 64;
  localparam int LBH_BASE_W   = 5;
  localparam int LBH_MUL_W    = 32;

  localparam logic [LBH_BASE_W-1:0] LBH_BASE_RESET = 5'd2;
  localparam logic [LBH_BASE_W-1:0] LBH_BASE_MIN   = 5'd2;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the bucket counter store.
`default_nettype none

module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbh_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on lbh_pkg; serves both the sample square and the bucket search.
`default_nettype none

module lbh_mul
  import lbh_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [LBH_MUL_W-1:0]     a,
  input  wire logic [LBH_MUL_W-1:0]     b,
  output logic      [2*LBH_MUL_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/log_bucket_histogram_stats.sv =====
// Top level of the log-bucket histogram: sequencer, statistics registers,
// shared multiplier (lbh_mul) and the bucket counter RAM (lbh_ram).
// Depends on lbh_pkg.
//
//  channel   | signals                                   | flow control
//  ----------+-------------------------------------------+----------------------
//  config    | cfg_wr_en, cfg_wr_data                    | taken every enabled edge
//  command   | start, mode, sample, bucket_index         | taken when start && !busy
//  result    | done, bucket_hit .. any_seen              | one-cycle strobe, no stall
//
// Add: the square is formed, then the bucket search makes n passes through
// the one shared multiplier (1 to SAMPLE_BITS - 1, none for a sample below
// one); then the counter is read and written back before the result strobe.
// Read and clear: the counter is read before the result strobe.
// A new beat may be taken in the strobe cycle. Reset clears the counters at
// once through per-bucket valid bits; the receiver cannot stall the block.
`default_nettype none

module log_bucket_histogram_stats
  import lbh_pkg::*;
#(
  parameter int NUM_BUCKETS = LBH_NUM_BUCKETS_DEF,
  parameter int SAMPLE_BITS = LBH_SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic        [LBH_BASE_W-1:0]  cfg_wr_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic        [1:0]             mode,
  input  wire logic signed [LBH_SAMPLE_W-1:0] sample,
  input  wire logic        [LBH_INDEX_W-1:0] bucket_index,
  output logic                               done,
  output logic        [LBH_INDEX_W-1:0]      bucket_hit,
  output logic        [LBH_COUNT_W-1:0]      bucket_total,
  output logic        [LBH_COUNT_W-1:0]      sample_total,
  output logic signed [LBH_STAT_W-1:0]       running_sum,
  output logic        [LBH_STAT_W-1:0]       square_sum,
  output logic signed [LBH_SAMPLE_W-1:0]     smallest,
  output logic signed [LBH_SAMPLE_W-1:0]     largest,
  output logic                               any_seen
);

  localparam int AW = $clog2(NUM_BUCKETS);
  localparam int IW = (AW > LBH_INDEX_W) ? AW : LBH_INDEX_W;
  localparam int KW = $clog2(SAMPLE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_FIRST,
    S_SEARCH,
    S_READ,
    S_UPDATE
  } state_t;

  state_t                        state;
  mode_t                         mode_q;
  logic signed [LBH_SAMPLE_W-1:0] sample_q;
  logic [LBH_INDEX_W-1:0]        index_q;
  logic                          index_ok_q;
  logic [AW-1:0]                 hit_q;
  logic [KW-1:0]                 k_q;
  logic [LBH_STAT_W-1:0]         sq_q;
  logic [LBH_BASE_W-1:0]         log_base;
  logic [NUM_BUCKETS-1:0]        valid_q;

  logic signed [LBH_SAMPLE_W-1:0] sample_ext;
  logic [IW-1:0]                 index_wide;
  logic [LBH_SAMPLE_W-1:0]       magnitude;
  logic [LBH_BASE_W-1:0]         base_eff;
  logic [31:0]                   k_plus;
  logic [AW-1:0]                 hit_clamp;
  logic                          fits;

  logic                          mul_en;
  logic [LBH_MUL_W-1:0]          mul_a;
  logic [LBH_MUL_W-1:0]          mul_b;
  logic [2*LBH_MUL_W-1:0]        prod;

  logic                          ram_we;
  logic                          ram_re;
  logic [LBH_COUNT_W-1:0]        ram_rdata;
  logic [LBH_COUNT_W-1:0]        count_cur;
  logic [LBH_COUNT_W-1:0]        count_inc;
  logic [LBH_STAT_W:0]           square_add;

  // Only the low SAMPLE_BITS bits of the sample count, as two's complement.
  assign sample_ext = LBH_SAMPLE_W'(signed'(sample[SAMPLE_BITS-1:0]));
  assign index_wide = IW'(bucket_index);
  assign magnitude  = sample_q[LBH_SAMPLE_W-1] ? $unsigned(-sample_q) : $unsigned(sample_q);
  assign base_eff   = (log_base < LBH_BASE_MIN) ? LBH_BASE_MIN : log_base;
  assign k_plus     = 32'(k_q) + 32'd1;
  assign hit_clamp  = (k_plus > 32'(NUM_BUCKETS - 1)) ? AW'(NUM_BUCKETS - 1) : AW'(k_plus);
  // The power of the base does not exceed the sample, so the search goes on.
  assign fits       = prod <= {{(LBH_STAT_W-LBH_SAMPLE_W){1'b0}}, $unsigned(sample_q)};

  assign busy = (state != S_IDLE);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_SQUARE: begin
        mul_en = 1'b1;
        mul_a  = magnitude;
        mul_b  = magnitude;
      end
      S_FIRST: begin
        mul_en = 1'b1;
        mul_a  = LBH_MUL_W'(1);
        mul_b  = LBH_MUL_W'(base_eff);
      end
      S_SEARCH: begin
        mul_en = 1'b1;
        mul_a  = prod[LBH_MUL_W-1:0];
        mul_b  = LBH_MUL_W'(base_eff);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign ram_re     = (state == S_READ);
  assign ram_we     = (state == S_UPDATE) && (mode_q == MODE_ADD);
  assign count_cur  = valid_q[hit_q] ? ram_rdata : '0;
  assign count_inc  = (count_cur == '1) ? count_cur : count_cur + LBH_COUNT_W'(1);
  assign square_add = {1'b0, square_sum} + {1'b0, sq_q};

  lbh_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  lbh_ram #(
    .WIDTH (LBH_COUNT_W),
    .DEPTH (NUM_BUCKETS)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_q),
    .wdata (count_inc),
    .re    (ram_re),
    .raddr (hit_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      log_base     <= LBH_BASE_RESET;
      valid_q      <= '0;
      sample_total <= '0;
      running_sum  <= '0;
      square_sum   <= '0;
      smallest     <= '0;
      largest      <= '0;
      any_seen     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        log_base <= cfg_wr_data;
      end
      done <= (state == S_UPDATE);
      case (state)
        S_IDLE: begin
          if (start) begin
            mode_q     <= mode_t'(mode);
            sample_q   <= sample_ext;
            index_q    <= bucket_index;
            index_ok_q <= 32'(bucket_index) < 32'(NUM_BUCKETS);
            hit_q      <= index_wide[AW-1:0];
            k_q        <= '0;
            state      <= (mode_t'(mode) == MODE_ADD) ? S_SQUARE : S_READ;
          end
        end
        S_SQUARE: begin
          state <= S_FIRST;
        end
        S_FIRST: begin
          sq_q <= prod;
          if (sample_q < 32'sd1) begin
            hit_q <= '0;
            state <= S_READ;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (fits) begin
            k_q <= k_q + KW'(1);
          end else begin
            hit_q <= hit_clamp;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_IDLE;
          case (mode_q)
            MODE_ADD: begin
              bucket_hit     <= LBH_INDEX_W'(hit_q);
              bucket_total   <= count_inc;
              valid_q[hit_q] <= 1'b1;
              if (sample_total != '1) begin
                sample_total <= sample_total + LBH_COUNT_W'(1);
              end
              running_sum <= running_sum + LBH_STAT_W'(sample_q);
              square_sum  <= square_add[LBH_STAT_W] ? '1 : square_add[LBH_STAT_W-1:0];
              any_seen    <= 1'b1;
              if (!any_seen) begin
                smallest <= sample_q;
                largest  <= sample_q;
              end else begin
                if (sample_q < smallest) begin
                  smallest <= sample_q;
                end
                if (sample_q > largest) begin
                  largest <= sample_q;
                end
              end
            end
            MODE_CLEAR: begin
              bucket_hit   <= index_q;
              bucket_total <= '0;
              valid_q      <= '0;
              sample_total <= '0;
              running_sum  <= '0;
              square_sum   <= '0;
              smallest     <= '0;
              largest      <= '0;
              any_seen     <= 1'b0;
            end
            default: begin
              bucket_hit   <= index_q;
              bucket_total <= index_ok_q ? count_cur : '0;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbh_chk.sv =====
// Port-level checker for the log-bucket histogram, bound to the top level.
// Depends on lbh_pkg and the assertion macros in log_bucket_histogram_stats_assert.svh.
`default_nettype none
`include "log_bucket_histogram_stats_assert.svh"

module lbh_chk
  import lbh_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic                           done,
  input  wire logic        [LBH_COUNT_W-1:0]  sample_total,
  input  wire logic signed [LBH_SAMPLE_W-1:0] smallest,
  input  wire logic signed [LBH_SAMPLE_W-1:0] largest,
  input  wire logic                           any_seen
);

  logic taken;
  logic stats_zero;

  assign taken      = start && !busy;
  assign stats_zero = (smallest == '0) && (largest == '0) && (sample_total == '0);

  // A taken beat must set the block busy.
  `LBH_ASSERT_NEXT(a_accept_busy, clk, rst, taken, busy, "taken beat left block idle")

  `LBH_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobe while still busy")

  `LBH_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held for two cycles")

  // With no sample since the last clear, smallest, largest and the sample total must read zero.
  `LBH_ASSERT_SAME(a_unseen_zero, clk, rst, done && !any_seen, stats_zero, "statistics set")

  `LBH_ASSERT_SAME(a_min_max, clk, rst, done && any_seen, smallest <= largest, "min above max")

endmodule

bind log_bucket_histogram_stats lbh_chk u_lbh_chk (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for log_bucket_histogram_stats: named tests drive command beats
// and an in-bench predictor checks every result strobe field by field.
// Depends on lbh_pkg and the log_bucket_histogram_stats RTL.
`timescale 1ns / 1ps

module tb_top;
  import lbh_pkg::*;

  localparam int BUCKETS     = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_BEATS = 258;

  typedef struct {
    logic        [LBH_INDEX_W-1:0]  hit;
    logic        [LBH_COUNT_W-1:0]  hit_count;
    logic        [LBH_COUNT_W-1:0]  n_samples;
    logic signed [LBH_STAT_W-1:0]   sum;
    logic        [LBH_STAT_W-1:0]   sq_sum;
    logic signed [LBH_SAMPLE_W-1:0] lo;
    logic signed [LBH_SAMPLE_W-1:0] hi;
    logic                           seen;
  } stats_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic        [LBH_BASE_W-1:0]    cfg_wr_data = '0;
  logic                            start = 1'b0;
  logic                            busy;
  mode_t                           mode = MODE_READ;
  logic signed [LBH_SAMPLE_W-1:0]  sample = '0;
  logic        [LBH_INDEX_W-1:0]   bucket_index = '0;
  logic                            done;
  logic        [LBH_INDEX_W-1:0]   bucket_hit;
  logic        [LBH_COUNT_W-1:0]   bucket_total;
  logic        [LBH_COUNT_W-1:0]   sample_total;
  logic signed [LBH_STAT_W-1:0]    running_sum;
  logic        [LBH_STAT_W-1:0]    square_sum;
  logic signed [LBH_SAMPLE_W-1:0]  smallest;
  logic signed [LBH_SAMPLE_W-1:0]  largest;
  logic                            any_seen;

  // Shadow of the block's state, updated as each command beat is taken.
  logic        [LBH_BASE_W-1:0]    base_shadow;
  logic        [LBH_COUNT_W-1:0]   hist_count [BUCKETS];
  logic        [LBH_COUNT_W-1:0]   samples_seen;
  logic signed [LBH_STAT_W-1:0]    sum_shadow;
  logic        [LBH_STAT_W-1:0]    sq_shadow;
  logic signed [LBH_SAMPLE_W-1:0]  lo_shadow;
  logic signed [LBH_SAMPLE_W-1:0]  hi_shadow;
  logic                            seen_shadow;

  stats_t stats_due [$];
  int     failures = 0;
  int     quiet_cycles = 0;
  int     idle_pct = 0;
  logic [LBH_INDEX_W-1:0] last_hit = '0;

  log_bucket_histogram_stats uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .sample       (sample),
    .bucket_index (bucket_index),
    .done         (done),
    .bucket_hit   (bucket_hit),
    .bucket_total (bucket_total),
    .sample_total (sample_total),
    .running_sum  (running_sum),
    .square_sum   (square_sum),
    .smallest     (smallest),
    .largest      (largest),
    .any_seen     (any_seen)
  );

  always #5 clk = ~clk;

  function automatic void wipe_histogram();
    for (int i = 0; i < BUCKETS; i++) hist_count[i] = '0;
    samples_seen = '0;
    sum_shadow   = '0;
    sq_shadow    = '0;
    lo_shadow    = '0;
    hi_shadow    = '0;
    seen_shadow  = 1'b0;
  endfunction

  function automatic int unsigned effective_base();
    return 32'((base_shadow < LBH_BASE_MIN) ? LBH_BASE_MIN : base_shadow);
  endfunction

  // Bucket 1 + k for the largest k with base^k <= value, found by exact powers.
  function automatic int unsigned bucket_of(logic signed [LBH_SAMPLE_W-1:0] s);
    longint unsigned b;
    longint unsigned p;
    longint unsigned v;
    int unsigned     k;
    if (s < 1) return 0;
    b = 64'(effective_base());
    v = longint'(s);
    p = 64'd1;
    k = 0;
    while (p * b <= v) begin
      p = p * b;
      k++;
    end
    k++;
    if (k > BUCKETS - 1) k = BUCKETS - 1;
    return k;
  endfunction

  function automatic stats_t histogram_update(mode_t m, logic signed [LBH_SAMPLE_W-1:0] s,
                                              logic [LBH_INDEX_W-1:0] idx);
    stats_t          r;
    longint          sv;
    longint unsigned mag;
    longint unsigned sq;
    int unsigned     hit;
    hit = 32'(idx);
    if (m == MODE_ADD) begin
      sv  = longint'(s);
      mag = (sv < 0) ? longint'(-sv) : longint'(sv);
      sq  = mag * mag;
      hit = bucket_of(s);
      if (hist_count[hit] != '1) hist_count[hit] = hist_count[hit] + LBH_COUNT_W'(1);
      if (!seen_shadow) begin
        seen_shadow = 1'b1;
        lo_shadow   = s;
        hi_shadow   = s;
      end else begin
        if (s < lo_shadow) lo_shadow = s;
        if (s > hi_shadow) hi_shadow = s;
      end
      if (samples_seen != '1) samples_seen = samples_seen + LBH_COUNT_W'(1);
      sum_shadow = sum_shadow + sv;
      if (sq_shadow > ~sq) sq_shadow = '1;
      else sq_shadow = sq_shadow + sq;
    end else if (m == MODE_CLEAR) begin
      wipe_histogram();
    end
    r.hit       = hit[LBH_INDEX_W-1:0];
    r.hit_count = (hit < BUCKETS) ? hist_count[hit] : '0;
    r.n_samples = samples_seen;
    r.sum       = sum_shadow;
    r.sq_sum    = sq_shadow;
    r.lo        = lo_shadow;
    r.hi        = hi_shadow;
    r.seen      = seen_shadow;
    return r;
  endfunction

  // Result checker: every strobe is matched against the oldest outstanding beat.
  always @(posedge clk) begin
    stats_t e;
    if (!rst && done) begin
      if (stats_due.size() == 0) begin
        $error("result strobe with no command outstanding");
        failures++;
      end else begin
        e = stats_due.pop_front();
        if (bucket_hit !== e.hit) begin
          $error("bucket_hit: expected %0d, actual %0d", e.hit, bucket_hit);
          failures++;
        end
        if (bucket_total !== e.hit_count) begin
          $error("bucket_total: expected %0d, actual %0d", e.hit_count, bucket_total);
          failures++;
        end
        if (sample_total !== e.n_samples) begin
          $error("sample_total: expected %0d, actual %0d", e.n_samples, sample_total);
          failures++;
        end
        if (running_sum !== e.sum) begin
          $error("running_sum: expected %0d, actual %0d", e.sum, running_sum);
          failures++;
        end
        if (square_sum !== e.sq_sum) begin
          $error("square_sum: expected %0d, actual %0d", e.sq_sum, square_sum);
          failures++;
        end
        if (smallest !== e.lo) begin
          $error("smallest: expected %0d, actual %0d", e.lo, smallest);
          failures++;
        end
        if (largest !== e.hi) begin
          $error("largest: expected %0d, actual %0d", e.hi, largest);
          failures++;
        end
        if (any_seen !== e.seen) begin
          $error("any_seen: expected %0d, actual %0d", e.seen, any_seen);
          failures++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a command beat nor a result is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Called at a rising edge; returns at the edge that takes the beat, with start left high.
  task automatic send_beat(mode_t m, logic signed [LBH_SAMPLE_W-1:0] s,
                           logic [LBH_INDEX_W-1:0] idx);
    start        <= 1'b1;
    mode         <= m;
    sample       <= s;
    bucket_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    stats_due = {stats_due, histogram_update(m, s, idx)};
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (stats_due.size() == 0);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_log_base(logic [LBH_BASE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    base_shadow = v;
  endtask

  function automatic logic [LBH_SAMPLE_W-1:0] random_sample();
    logic [LBH_SAMPLE_W-1:0] r;
    longint unsigned         p;
    longint unsigned         b;
    int unsigned             w;
    if ($urandom_range(99) < 20) begin
      // Exact powers of the base and their neighbours sit on bucket boundaries.
      b = 64'(effective_base());
      p = 64'd1;
      repeat ($urandom_range(31)) if (p * b <= 64'h7FFF_FFFF) p = p * b;
      r = p[LBH_SAMPLE_W-1:0] + $urandom_range(2) - 1;
    end else begin
      w = $urandom_range(32);
      r = $urandom;
      if (w < 32) r = r & ((32'd1 << w) - 1);
    end
    if ($urandom_range(99) < 15) r = -r;
    return r;
  endfunction

  task automatic test_reset_state();
    send_beat(MODE_READ, '0, 6'd0);
    send_beat(MODE_READ, '0, 6'd63);
    drain();
  endtask

  task automatic test_sample_extremes();
    send_beat(MODE_ADD, 32'sd0, 6'd0);
    send_beat(MODE_ADD, 32'sd1, 6'd63);
    send_beat(MODE_ADD, -32'sd1, 6'd0);
    send_beat(MODE_ADD, 32'sd2, 6'd0);
    send_beat(MODE_ADD, 32'sd3, 6'd0);
    send_beat(MODE_ADD, 32'sd4, 6'd0);
    send_beat(MODE_ADD, 32'sh7FFF_FFFF, 6'd0);
    send_beat(MODE_ADD, 32'sh8000_0000, 6'd0);
    drain();
  endtask

  // The square of the most negative sample is 2^62, so a few of them saturate the square sum.
  task automatic test_square_saturation();
    repeat (4) send_beat(MODE_ADD, 32'sh8000_0000, 6'd0);
    drain();
  endtask

  task automatic test_modes();
    send_beat(MODE_SPARE, 32'sd12345, 6'd2);
    send_beat(MODE_READ, '0, 6'd31);
    send_beat(MODE_CLEAR, '1, 6'd63);
    send_beat(MODE_READ, '0, 6'd1);
    drain();
  endtask

  task automatic test_base_settings();
    set_log_base(5'd0);
    send_beat(MODE_ADD, 32'sd8, 6'd0);
    set_log_base(5'd1);
    send_beat(MODE_ADD, 32'sd7, 6'd0);
    set_log_base(5'd16);
    send_beat(MODE_ADD, 32'sd15, 6'd0);
    send_beat(MODE_ADD, 32'sd16, 6'd0);
    send_beat(MODE_ADD, 32'sd256, 6'd0);
    set_log_base(5'd17);
    send_beat(MODE_ADD, 32'sd289, 6'd0);
    set_log_base(5'd31);
    send_beat(MODE_ADD, 32'sd30, 6'd0);
    send_beat(MODE_ADD, 32'sd961, 6'd0);
    send_beat(MODE_ADD, 32'sh7FFF_FFFF, 6'd0);
    drain();
  endtask

  task automatic test_random_traffic(int pct, logic [LBH_BASE_W-1:0] base_val,
                                     bit pause_midway);
    int unsigned pick;
    logic [LBH_INDEX_W-1:0] idx;
    set_log_base(base_val);
    idle_pct = pct;
    for (int i = 0; i < PHASE_BEATS; i++) begin
      idle_gap();
      if (pause_midway && i == PHASE_BEATS / 2) drain();
      pick = $urandom_range(99);
      idx  = ($urandom_range(1) == 0) ? last_hit : 6'($urandom);
      if (pick < 70) begin
        send_beat(MODE_ADD, random_sample(), 6'($urandom));
        last_hit = stats_due[$].hit;
      end else if (pick < 88) begin
        send_beat(MODE_READ, 32'($urandom), idx);
      end else if (pick < 94) begin
        send_beat(MODE_CLEAR, 32'($urandom), idx);
      end else begin
        send_beat(MODE_SPARE, 32'($urandom), idx);
      end
    end
    drain();
  endtask

  initial begin
    base_shadow = LBH_BASE_RESET;
    wipe_histogram();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_sample_extremes();
    test_square_saturation();
    test_modes();
    test_base_settings();
    test_random_traffic(0, 5'd2, 1'b0);
    test_random_traffic(0, 5'($urandom_range(3, 15)), 1'b1);
    test_random_traffic(81, 5'd16, 1'b0);
    test_random_traffic(81, 5'd31, 1'b0);
    test_random_traffic(13, 5'($urandom_range(1)), 1'b0);
    test_random_traffic(13, 5'($urandom_range(31)), 1'b0);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lbh_pkg.sv
hw/rtl/lbh_ram.sv
hw/rtl/lbh_mul.sv
hw/rtl/log_bucket_histogram_stats.sv
hw/rtl/lbh_chk.sv
sim/tb_top.sv
